// ----- hdl/mw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial EEPROM master package
// Shared constants, codes and types of the three-wire EEPROM master.
// ----------------------------------------------------------------------------
package mw_pkg;

  localparam int ADDR_BITS_DEF = 7;

  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_READ  = 3'd1;
  localparam logic [2:0] ACT_WRITE = 3'd2;
  localparam logic [2:0] ACT_EWEN  = 3'd3;
  localparam logic [2:0] ACT_EWDS  = 3'd4;

  localparam logic [1:0] OP_READ  = 2'b10;
  localparam logic [1:0] OP_WRITE = 2'b01;
  localparam logic [1:0] OP_MISC  = 2'b00;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_SEND  = 5'b00010,
    PH_RECV  = 5'b00100,
    PH_RAISE = 5'b01000,
    PH_POLL  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       chip_select;
    logic       serial_clock;
    logic       data_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       rejected;
  } mw_res_t;

  typedef struct packed {
    logic    valid;
    mw_res_t res;
  } mw_push_t;

endpackage

// ----- hdl/mw_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command or tick beat.
// ----------------------------------------------------------------------------
interface mw_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [6:0] address;
  logic [7:0] write_data;
  logic       miso;

  modport source (output valid, action, address, write_data, miso, input ready);
  modport sink (input valid, action, address, write_data, miso, output ready);
endinterface

// ----- hdl/mw_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result beat per accepted input beat.
// ----------------------------------------------------------------------------
interface mw_out_if;
  logic       valid;
  logic       ready;
  logic       chip_select;
  logic       serial_clock;
  logic       data_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       rejected;

  modport source (output valid, chip_select, serial_clock, data_out, busy_res, done_res,
                  read_byte, rejected, input ready);
  modport sink (input valid, chip_select, serial_clock, data_out, busy_res, done_res,
                read_byte, rejected, output ready);
endinterface

// ----- hdl/mw_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pin sequencer
// Holds the bus state and advances it on accepted ticks, one half-bit per tick while shifting.
// ----------------------------------------------------------------------------
module mw_seq #(
  parameter int ADDR_BITS = mw_pkg::ADDR_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  mw_in_if.sink          in_ch,
  input  logic           ready_i,
  output mw_pkg::mw_push_t push_o
);

  localparam int SW = ADDR_BITS + 11;
  localparam int CW = $clog2(SW + 1);
  localparam int IW = $clog2(SW);

  mw_pkg::phase_t  phase_r, phase_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [SW-1:0]   shift_r, shift_nxt;
  logic [7:0]      in_shift_r, in_shift_nxt;
  logic [2:0]      act_r, act_nxt;
  logic            cs_r, cs_nxt;
  logic            sclk_r, sclk_nxt;
  logic            dout_r, dout_nxt;

  logic                 accept;
  logic                 is_cmd;
  logic                 done;
  logic                 rej;
  logic [7:0]           rbyte;
  logic [1:0]           op;
  logic [ADDR_BITS-1:0] addr_bits;
  logic [ADDR_BITS+6:0] addr_ext;
  logic [ADDR_BITS+2:0] base;
  logic [CW-1:0]        idx_full;
  logic [IW-1:0]        idx;

  assign in_ch.ready = ready_i;
  assign accept      = in_ch.valid && ready_i;
  assign is_cmd      = (in_ch.action == mw_pkg::ACT_READ) || (in_ch.action == mw_pkg::ACT_WRITE)
                    || (in_ch.action == mw_pkg::ACT_EWEN) || (in_ch.action == mw_pkg::ACT_EWDS);
  assign addr_ext    = {{ADDR_BITS{1'b0}}, in_ch.address};
  assign idx_full    = cnt_r - CW'(2);
  assign idx         = idx_full[IW-1:0];

  always_comb begin
    op = mw_pkg::OP_MISC;
    addr_bits = '0;
    case (in_ch.action)
      mw_pkg::ACT_READ: begin
        op = mw_pkg::OP_READ;
        addr_bits = addr_ext[ADDR_BITS-1:0];
      end
      mw_pkg::ACT_WRITE: begin
        op = mw_pkg::OP_WRITE;
        addr_bits = addr_ext[ADDR_BITS-1:0];
      end
      mw_pkg::ACT_EWEN: begin
        addr_bits = {2'b11, {(ADDR_BITS-2){1'b0}}};
      end
      default: begin
        addr_bits = '0;
      end
    endcase
    base = {1'b1, op, addr_bits};
  end

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    shift_nxt    = shift_r;
    in_shift_nxt = in_shift_r;
    act_nxt      = act_r;
    cs_nxt       = cs_r;
    sclk_nxt     = sclk_r;
    dout_nxt     = dout_r;
    done         = 1'b0;
    rej          = 1'b0;
    rbyte        = 8'd0;
    if (accept && is_cmd) begin
      if (phase_r != mw_pkg::PH_IDLE) begin
        rej = 1'b1;
      end else begin
        if (in_ch.action == mw_pkg::ACT_WRITE) begin
          shift_nxt = {base, in_ch.write_data};
          cnt_nxt   = CW'(ADDR_BITS + 11);
        end else begin
          shift_nxt = {8'd0, base};
          cnt_nxt   = CW'(ADDR_BITS + 3);
        end
        in_shift_nxt = 8'd0;
        act_nxt      = in_ch.action;
        phase_nxt    = mw_pkg::PH_SEND;
        cs_nxt       = 1'b1;
        sclk_nxt     = 1'b0;
        dout_nxt     = 1'b1;
      end
    end else if (accept && (in_ch.action == mw_pkg::ACT_TICK)) begin
      case (phase_r)
        mw_pkg::PH_IDLE: begin
          phase_nxt = mw_pkg::PH_IDLE;
        end
        mw_pkg::PH_SEND: begin
          if (!sclk_r) begin
            sclk_nxt = 1'b1;
          end else begin
            cnt_nxt  = cnt_r - CW'(1);
            sclk_nxt = 1'b0;
            if (cnt_r > CW'(1)) begin
              cs_nxt   = 1'b1;
              dout_nxt = shift_r[idx];
            end else if (act_r == mw_pkg::ACT_READ) begin
              cs_nxt    = 1'b1;
              dout_nxt  = 1'b0;
              phase_nxt = mw_pkg::PH_RECV;
            end else if (act_r == mw_pkg::ACT_WRITE) begin
              cs_nxt    = 1'b0;
              dout_nxt  = 1'b0;
              phase_nxt = mw_pkg::PH_RAISE;
            end else begin
              cs_nxt    = 1'b0;
              dout_nxt  = 1'b0;
              phase_nxt = mw_pkg::PH_IDLE;
              done      = 1'b1;
            end
          end
        end
        mw_pkg::PH_RECV: begin
          if (!sclk_r) begin
            sclk_nxt = 1'b1;
          end else begin
            in_shift_nxt = {in_shift_r[6:0], in_ch.miso};
            sclk_nxt     = 1'b0;
            dout_nxt     = 1'b0;
            if (cnt_r >= CW'(7)) begin
              cs_nxt    = 1'b0;
              phase_nxt = mw_pkg::PH_IDLE;
              cnt_nxt   = '0;
              done      = 1'b1;
              rbyte     = {in_shift_r[6:0], in_ch.miso};
            end else begin
              cs_nxt  = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
        end
        mw_pkg::PH_RAISE: begin
          cs_nxt    = 1'b1;
          sclk_nxt  = 1'b0;
          dout_nxt  = 1'b0;
          phase_nxt = mw_pkg::PH_POLL;
        end
        mw_pkg::PH_POLL: begin
          if (in_ch.miso) begin
            cs_nxt    = 1'b0;
            sclk_nxt  = 1'b0;
            dout_nxt  = 1'b0;
            phase_nxt = mw_pkg::PH_IDLE;
            done      = 1'b1;
          end
        end
        default: begin
          phase_nxt = mw_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= mw_pkg::PH_IDLE;
      cnt_r      <= '0;
      shift_r    <= '0;
      in_shift_r <= 8'd0;
      act_r      <= mw_pkg::ACT_TICK;
      cs_r       <= 1'b0;
      sclk_r     <= 1'b0;
      dout_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      shift_r    <= shift_nxt;
      in_shift_r <= in_shift_nxt;
      act_r      <= act_nxt;
      cs_r       <= cs_nxt;
      sclk_r     <= sclk_nxt;
      dout_r     <= dout_nxt;
    end
  end

  always_comb begin
    push_o.valid            = accept;
    push_o.res.chip_select  = cs_nxt;
    push_o.res.serial_clock = sclk_nxt;
    push_o.res.data_out     = dout_nxt;
    push_o.res.busy_res     = (phase_nxt != mw_pkg::PH_IDLE);
    push_o.res.done_res     = done;
    push_o.res.read_byte    = rbyte;
    push_o.res.rejected     = rej;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    push_o.valid && push_o.res.done_res |=> phase_r == mw_pkg::PH_IDLE)
    else $error("finished command left the sequencer busy");

  a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
    push_o.valid && push_o.res.rejected |=> $stable(phase_r) && $stable(cnt_r)
      && $stable(shift_r))
    else $error("rejected command changed the sequencer state");

  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == mw_pkg::PH_IDLE |-> !cs_r && !sclk_r)
    else $error("select or clock high while idle");

endmodule

// ----- hdl/mw_obuf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry output register with skid stage for the result channel.
// ----------------------------------------------------------------------------
module mw_obuf (
  input  logic             clk,
  input  logic             rst_n,
  input  mw_pkg::mw_push_t push_i,
  output logic             ready_o,
  mw_out_if.source         out_ch
);

  mw_pkg::mw_res_t main_r;
  mw_pkg::mw_res_t skid_r;
  logic            main_v_r;
  logic            skid_v_r;

  assign ready_o = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push_i.valid;
      end
    end else if (push_i.valid) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || out_ch.ready) begin
      main_r <= skid_v_r ? skid_r : push_i.res;
    end else if (push_i.valid) begin
      skid_r <= push_i.res;
    end
  end

  assign out_ch.valid        = main_v_r;
  assign out_ch.chip_select  = main_r.chip_select;
  assign out_ch.serial_clock = main_r.serial_clock;
  assign out_ch.data_out     = main_r.data_out;
  assign out_ch.busy_res     = main_r.busy_res;
  assign out_ch.done_res     = main_r.done_res;
  assign out_ch.read_byte    = main_r.read_byte;
  assign out_ch.rejected     = main_r.rejected;

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry held while output register empty");

endmodule

// ----- hdl/microwire_eeprom_master_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-wire serial EEPROM master
// Drives select, clock and data-out of an x8 serial EEPROM, one half-bit per
// tick beat, and reports pin levels and command status for every beat.
// ----------------------------------------------------------------------------
// The block takes one command or tick beat per clock and returns exactly one
// result beat for each, registered in an output register backed by a skid
// entry; the pin sequencer updates its whole state in the accepting cycle, so
// throughput is one beat per clock while the result channel keeps up, and
// input ready drops only when both output entries are full.
module microwire_eeprom_master_top #(
  parameter int ADDR_BITS = mw_pkg::ADDR_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  mw_in_if.sink     in_ch,
  mw_out_if.source  out_ch
);

  mw_pkg::mw_push_t push;
  logic             buf_ready;

  mw_seq #(
    .ADDR_BITS (ADDR_BITS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .ready_i (buf_ready),
    .push_o  (push)
  );

  mw_obuf u_obuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .ready_o (buf_ready),
    .out_ch  (out_ch)
  );

endmodule
